[design/mips_subset_execute_unit_assert.svh]
// Assertion macros for the execute unit.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/mse_pkg.sv]
package mse_pkg;

    localparam int DATA_BYTES = 1024;
    localparam int MEM_WORDS  = (DATA_BYTES + 3) / 4;
    localparam int MEM_AW     = $clog2(MEM_WORDS);

    typedef enum logic [4:0] {
        OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOR, OP_NAND, OP_SLT,
        OP_SLL, OP_SRL, OP_SRA, OP_JR, OP_ADDI, OP_LW, OP_LH, OP_LHU,
        OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB, OP_LUI, OP_ANDI, OP_ORI,
        OP_NORI, OP_SLTI, OP_BEQ, OP_BNE, OP_J, OP_JAL, OP_HALT, OP_PRELOAD
    } t_op;

    typedef enum logic {
        CFG_START_PC   = 1'b0,
        CFG_STACK_INIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_op          operation;
        logic [4:0]   src_reg;
        logic [4:0]   second_reg;
        logic [4:0]   dest_reg;
        logic [4:0]   shift_amount;
        logic signed [15:0] immediate;
        logic [25:0]  jump_target;
        logic [31:0]  preload_value;
    } t_in;

    typedef struct packed {
        logic [31:0] pc_before;
        logic [31:0] pc_after;
        logic        reg_written;
        logic [4:0]  reg_index_out;
        logic [31:0] reg_value_out;
        logic        overflow_flag;
        logic        zero_write_flag;
        logic        address_flag;
        logic        misalign_flag;
        logic        halted;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] idx;
        logic [31:0]       data;
    } t_mem_wr;

    typedef struct packed {
        logic        we;
        logic [4:0]  idx;
        logic [31:0] data;
    } t_reg_wr;

endpackage

[design/mse_regfile.sv]
module mse_regfile (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mse_pkg::t_reg_wr      i_wr,
    input  logic                  i_init,
    input  logic [31:0]           i_init_value,
    input  logic [4:0]            i_ra,
    input  logic [4:0]            i_rb,
    output logic [31:0]           o_a,
    output logic [31:0]           o_b
);
    localparam logic [4:0] SP_IDX = 5'd29;

    logic [31:0] r_regs [32];

    assign o_a = r_regs[i_ra];
    assign o_b = r_regs[i_rb];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) r_regs[i] <= '0;
        end else begin
            if (i_init) r_regs[SP_IDX] <= i_init_value;
            // instruction write lands after the stack init
            if (i_wr.we) r_regs[i_wr.idx] <= i_wr.data;
        end
    end
endmodule

[design/mse_dmem.sv]
module mse_dmem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [mse_pkg::MEM_AW-1:0] i_rd_idx,
    output logic [31:0]               o_rd_data,
    input  mse_pkg::t_mem_wr          i_wr
);
    logic [31:0]                 r_mem [mse_pkg::MEM_WORDS];
    logic [mse_pkg::MEM_WORDS-1:0] r_valid;
    logic [31:0]                 r_rd_data;
    logic                        r_rd_valid;

    // unwritten words read as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) r_mem[i_wr.idx] <= i_wr.data;
        if (i_rd_en) r_rd_data <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.we) r_valid[i_wr.idx] <= 1'b1;
            if (i_rd_en) r_rd_valid <= r_valid[i_rd_idx];
        end
    end
endmodule

[design/mips_subset_execute_unit.sv]
// Execute unit for a small MIPS-like core, one decoded instruction per word.
// Input channel: i_in_valid / o_in_ready carry one t_in word per instruction.
// Output channel: o_out_valid / i_out_ready carry one t_out word per input.
// Config: i_cfg_we with i_cfg_index writes start_pc (0) or stack_init (1);
// write only while the unit is drained.
// Pipeline: address stage (register read, address add, data memory read
// issue), execute stage (registered memory data, ALU, branch, writeback),
// then the output register. Throughput is one word per cycle while the
// output is not stalled; the data memory read port is the reason for
// the address stage, and register/memory writes of the execute stage
// are forwarded into the address stage.
// Reset: pipeline empty, register file and memory read as zero, PC is
// loaded from start_pc and r29 from stack_init on the first word.
// Stall: when the output word is not taken the whole pipeline holds and
// o_in_ready drops; nothing is lost or repeated.
// After a halt or fault every further word reports halted with the PC only.
module mips_subset_execute_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mse_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mse_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    `include "mips_subset_execute_unit_assert.svh"

    localparam logic [31:0] DBYTES = 32'(mse_pkg::DATA_BYTES);

    // config and architectural state
    logic [31:0] r_start_pc, r_stack_init, r_pc;
    logic        r_started, r_halt;

    // pipeline registers
    logic         r_s1_v, r_s2_v, r_out_v;
    mse_pkg::t_in r_s1, r_s2;
    logic [31:0]  r_a, r_b, r_addr;
    logic         r_hit;
    logic [31:0]  r_fwd;
    mse_pkg::t_out r_out;

    logic adv;
    assign adv         = !r_out_v || i_out_ready;
    assign o_in_ready  = adv;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // execute stage results
    mse_pkg::t_out   n_out;
    mse_pkg::t_reg_wr ex_rwr, rwr;
    mse_pkg::t_mem_wr ex_mwr, mwr;
    logic [31:0]     n_pc;
    logic            n_halt;
    logic            ex_fire;

    assign ex_fire = adv && r_s2_v;

    always_comb begin
        rwr    = ex_rwr;
        rwr.we = ex_rwr.we && ex_fire;
        mwr    = ex_mwr;
        mwr.we = ex_mwr.we && ex_fire;
    end

    // address stage: register read with forwarding
    logic [31:0] rf_a, rf_b, s1_a, s1_b, s1_addr, s1_simm;
    logic [mse_pkg::MEM_AW-1:0] s1_idx;
    logic [31:0] rd_word;

    mse_regfile u_regfile (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (rwr),
        .i_init       (ex_fire && !r_started),
        .i_init_value (r_stack_init),
        .i_ra         (r_s1.src_reg),
        .i_rb         (r_s1.second_reg),
        .o_a          (rf_a),
        .o_b          (rf_b)
    );

    function automatic logic [31:0] fwd_read(
        input logic [4:0] idx, input logic [31:0] rf, input mse_pkg::t_reg_wr wr,
        input logic init, input logic [31:0] init_v);
        logic [31:0] v;
        v = rf;
        if (init && idx == 5'd29) v = init_v;
        if (wr.we && wr.idx == idx) v = wr.data;
        return v;
    endfunction

    always_comb begin
        s1_a    = fwd_read(r_s1.src_reg, rf_a, rwr, !r_started, r_stack_init);
        s1_b    = fwd_read(r_s1.second_reg, rf_b, rwr, !r_started, r_stack_init);
        s1_simm = {{16{r_s1.immediate[15]}}, r_s1.immediate};
        s1_addr = s1_a + s1_simm;
        s1_idx  = s1_addr[mse_pkg::MEM_AW+1:2];
    end

    mse_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (adv),
        .i_rd_idx  (s1_idx),
        .o_rd_data (rd_word),
        .i_wr      (mwr)
    );

    // execute stage
    always_comb begin
        logic [31:0] pc, pc4, a, b, simm, val, word, mask, boff;
        logic [4:0]  lane, tr;
        logic        want, af, mf, ovf, zw, is_mem;
        mse_pkg::t_op op;
        op     = r_s2.operation;
        pc     = r_started ? r_pc : r_start_pc;
        pc4    = pc + 32'd4;
        a      = r_a;
        b      = r_b;
        simm   = {{16{r_s2.immediate[15]}}, r_s2.immediate};
        boff   = {simm[29:0], 2'b00};
        lane   = {r_addr[1:0], 3'b000};
        word   = r_hit ? r_fwd : rd_word;
        val    = '0;
        tr     = '0;
        want   = 1'b0;
        af     = 1'b0;
        mf     = 1'b0;
        ovf    = 1'b0;
        zw     = 1'b0;
        mask   = '0;
        n_pc   = pc;
        n_halt = r_halt;
        ex_rwr = '0;
        ex_mwr = '0;
        is_mem = (op >= mse_pkg::OP_LW) && (op <= mse_pkg::OP_SB);

        if (r_halt || op == mse_pkg::OP_PRELOAD) begin
            if (!r_halt && 32'(r_s2.jump_target) < 32'(mse_pkg::MEM_WORDS)) begin
                ex_mwr.we   = 1'b1;
                ex_mwr.idx  = r_s2.jump_target[mse_pkg::MEM_AW-1:0];
                ex_mwr.data = r_s2.preload_value;
            end
        end else if (pc >= DBYTES) begin
            af = 1'b1;
        end else if (pc[1:0] != 2'b00) begin
            mf = 1'b1;
        end else begin
            n_pc = pc4;
            if (is_mem) begin
                ovf = ~(a[31] ^ simm[31]) & (a[31] ^ r_addr[31]);
                if (r_addr >= DBYTES) af = 1'b1;
                else if ((op == mse_pkg::OP_LW || op == mse_pkg::OP_SW) && r_addr[1:0] != 2'b00)
                    mf = 1'b1;
                else if ((op == mse_pkg::OP_LH || op == mse_pkg::OP_LHU ||
                          op == mse_pkg::OP_SH) && r_addr[0])
                    mf = 1'b1;
            end
            unique case (op)
                mse_pkg::OP_ADD: begin
                    val = a + b; ovf = ~(a[31] ^ b[31]) & (a[31] ^ val[31]);
                    tr = r_s2.dest_reg; want = 1'b1;
                end
                mse_pkg::OP_SUB: begin
                    val = a - b; ovf = (a[31] ^ b[31]) & (a[31] ^ val[31]);
                    tr = r_s2.dest_reg; want = 1'b1;
                end
                mse_pkg::OP_AND:  begin val = a & b;    tr = r_s2.dest_reg; want = 1'b1; end
                mse_pkg::OP_OR:   begin val = a | b;    tr = r_s2.dest_reg; want = 1'b1; end
                mse_pkg::OP_XOR:  begin val = a ^ b;    tr = r_s2.dest_reg; want = 1'b1; end
                mse_pkg::OP_NOR:  begin val = ~(a | b); tr = r_s2.dest_reg; want = 1'b1; end
                mse_pkg::OP_NAND: begin val = ~(a & b); tr = r_s2.dest_reg; want = 1'b1; end
                mse_pkg::OP_SLT: begin
                    val = {31'd0, $signed(a) < $signed(b)}; tr = r_s2.dest_reg; want = 1'b1;
                end
                mse_pkg::OP_SLL: begin
                    val = b << r_s2.shift_amount; tr = r_s2.dest_reg; want = 1'b1;
                end
                mse_pkg::OP_SRL: begin
                    val = b >> r_s2.shift_amount; tr = r_s2.dest_reg; want = 1'b1;
                end
                mse_pkg::OP_SRA: begin
                    val = 32'($signed(b) >>> r_s2.shift_amount);
                    tr = r_s2.dest_reg; want = 1'b1;
                end
                mse_pkg::OP_JR: n_pc = a;
                mse_pkg::OP_ADDI: begin
                    val = a + simm; ovf = ~(a[31] ^ simm[31]) & (a[31] ^ val[31]);
                    tr = r_s2.second_reg; want = 1'b1;
                end
                mse_pkg::OP_LW: begin val = word; tr = r_s2.second_reg; want = 1'b1; end
                mse_pkg::OP_LH: begin
                    val = word >> lane; val = {{16{val[15]}}, val[15:0]};
                    tr = r_s2.second_reg; want = 1'b1;
                end
                mse_pkg::OP_LHU: begin
                    val = word >> lane; val = {16'd0, val[15:0]};
                    tr = r_s2.second_reg; want = 1'b1;
                end
                mse_pkg::OP_LB: begin
                    val = word >> lane; val = {{24{val[7]}}, val[7:0]};
                    tr = r_s2.second_reg; want = 1'b1;
                end
                mse_pkg::OP_LBU: begin
                    val = word >> lane; val = {24'd0, val[7:0]};
                    tr = r_s2.second_reg; want = 1'b1;
                end
                mse_pkg::OP_SW, mse_pkg::OP_SH, mse_pkg::OP_SB: begin
                    if (op == mse_pkg::OP_SW)      mask = 32'hffff_ffff;
                    else if (op == mse_pkg::OP_SH) mask = 32'h0000_ffff << lane;
                    else                           mask = 32'h0000_00ff << lane;
                    if (!af && !mf) begin
                        ex_mwr.we   = 1'b1;
                        ex_mwr.idx  = r_addr[mse_pkg::MEM_AW+1:2];
                        ex_mwr.data = (word & ~mask) | ((b << lane) & mask);
                    end
                end
                mse_pkg::OP_LUI:  begin val = {simm[15:0], 16'd0}; tr = r_s2.second_reg; want = 1'b1; end
                mse_pkg::OP_ANDI: begin val = a & {16'd0, simm[15:0]}; tr = r_s2.second_reg; want = 1'b1; end
                mse_pkg::OP_ORI:  begin val = a | {16'd0, simm[15:0]}; tr = r_s2.second_reg; want = 1'b1; end
                mse_pkg::OP_NORI: begin
                    val = ~(a | {16'd0, simm[15:0]}); tr = r_s2.second_reg; want = 1'b1;
                end
                mse_pkg::OP_SLTI: begin
                    val = {31'd0, $signed(a) < $signed(simm)}; tr = r_s2.second_reg; want = 1'b1;
                end
                mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
                    if ((op == mse_pkg::OP_BEQ) == (a == b)) begin
                        n_pc = pc4 + boff;
                        ovf  = ~(pc4[31] ^ boff[31]) & (pc4[31] ^ n_pc[31]);
                    end
                end
                mse_pkg::OP_J: n_pc = {pc4[31:28], r_s2.jump_target, 2'b00};
                mse_pkg::OP_JAL: begin
                    val = pc4; tr = 5'd31; want = 1'b1;
                    n_pc = {pc4[31:28], r_s2.jump_target, 2'b00};
                end
                default: begin
                    // halt
                    n_halt = 1'b1; n_pc = pc;
                end
            endcase
            if (want && !af && !mf) begin
                if (tr == 5'd0) zw = 1'b1;
                else begin
                    ex_rwr.we = 1'b1; ex_rwr.idx = tr; ex_rwr.data = val;
                end
            end
        end
        if (af || mf) begin
            n_halt = 1'b1; n_pc = pc;
        end

        n_out.pc_before       = pc;
        n_out.pc_after        = n_pc;
        n_out.reg_written     = ex_rwr.we;
        n_out.reg_index_out   = ex_rwr.we ? ex_rwr.idx : 5'd0;
        n_out.reg_value_out   = ex_rwr.we ? ex_rwr.data : 32'd0;
        n_out.overflow_flag   = ovf;
        n_out.zero_write_flag = zw;
        n_out.address_flag    = af;
        n_out.misalign_flag   = mf;
        n_out.halted          = n_halt;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (o_in_ready && i_in_valid) r_s1 <= i_in_data;
            r_s2   <= r_s1;
            r_a    <= s1_a;
            r_b    <= s1_b;
            r_addr <= s1_addr;
            // same-edge memory write beats the stale read
            r_hit  <= mwr.we && (mwr.idx == s1_idx);
            r_fwd  <= mwr.data;
            if (r_s2_v) r_out <= n_out;
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc   <= '0;
            r_stack_init <= '0;
            r_pc         <= '0;
            r_started    <= 1'b0;
            r_halt       <= 1'b0;
            r_s1_v       <= 1'b0;
            r_s2_v       <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mse_pkg::CFG_START_PC) r_start_pc <= i_cfg_data;
                else                                      r_stack_init <= i_cfg_data;
            end
            if (adv) begin
                r_s1_v  <= i_in_valid;
                r_s2_v  <= r_s1_v;
                r_out_v <= r_s2_v;
            end
            if (ex_fire) begin
                r_started <= 1'b1;
                r_pc      <= n_pc;
                r_halt    <= n_halt;
            end
        end
    end

    `MSE_ASSERT_NEXT(a_halt_sticks, i_clk, i_rst_n, r_halt, r_halt)
    `MSE_ASSERT_SAME(a_halt_pc_holds, i_clk, i_rst_n, r_out_v && r_out.halted,
        r_out.pc_before == r_out.pc_after)
    `MSE_ASSERT_SAME(a_no_r0_write, i_clk, i_rst_n, r_out_v && r_out.reg_written,
        r_out.reg_index_out != 5'd0 && !r_out.zero_write_flag)
    `MSE_ASSERT_SAME(a_stall_only_on_out, i_clk, i_rst_n, !o_in_ready,
        r_out_v && !i_out_ready)
endmodule
